>>> rtl/core/mcgt_pkg.sv
// Shared constants, codes and types for the multicast group membership table.
// No dependencies; every other file of the block but mcgt_ram imports this package.
package mcgt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int REF_W       = 16;
	localparam int GADDR_W     = 32;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;
	localparam int MAXG_W      = 6;

	localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
	localparam logic [OP_W-1:0] OP_JOIN  = 2'd1;
	localparam logic [OP_W-1:0] OP_LEAVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GROUPS = 1'd1;

	localparam logic [3:0]       CLASS_D_PREFIX = 4'hE;
	localparam logic [REF_W-1:0] REF_MAX        = {REF_W{1'b1}};

	typedef struct packed {
		logic [GADDR_W-1:0] gaddr;
		logic [REF_W-1:0]   refs;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               enabled;
		logic [COUNT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_member;
		logic                notify_nic;
		logic                send_report;
		logic                send_leave;
	} flags_t;

endpackage

>>> rtl/core/mcgt_req_if.sv
// Request channel: valid/ready handshake carrying opcode and group address.
// Depends on mcgt_pkg for field widths.
interface mcgt_req_if;
	import mcgt_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [GADDR_W-1:0] group_addr;

	modport source (output valid, output opcode, output group_addr, input ready);
	modport sink   (input valid, input opcode, input group_addr, output ready);

endinterface

>>> rtl/core/mcgt_rsp_if.sv
// Response channel: valid/ready handshake carrying status, flags and group count.
// Depends on mcgt_pkg for field widths.
interface mcgt_rsp_if;
	import mcgt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                is_member;
	logic                notify_nic;
	logic                send_report;
	logic                send_leave;
	logic [COUNT_W-1:0]  group_count_now;

	modport source (output valid, output status, output is_member, output notify_nic,
		output send_report, output send_leave, output group_count_now, input ready);
	modport sink   (input valid, input status, input is_member, input notify_nic,
		input send_report, input send_leave, input group_count_now, output ready);

endinterface

>>> rtl/core/mcgt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module mcgt_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 48,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/mcgt_ctrl.sv
// Sequencer for the group table: linear scan, in-place update, append and
// shift-down compaction over the entry RAM. Depends on mcgt_pkg.
module mcgt_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mcgt_pkg::cfg_t           cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [mcgt_pkg::OP_W-1:0]    in_op,
	input  logic [mcgt_pkg::GADDR_W-1:0] in_addr,
	output logic                     res_valid,
	input  logic                     res_ready,
	output mcgt_pkg::flags_t         res_flags,
	output logic [mcgt_pkg::COUNT_W-1:0] res_count,
	output logic                     ram_we,
	output logic [mcgt_pkg::ADDR_W-1:0]  ram_waddr,
	output mcgt_pkg::entry_t         ram_wdata,
	output logic [mcgt_pkg::ADDR_W-1:0]  ram_raddr,
	input  mcgt_pkg::entry_t         ram_rdata
);
	import mcgt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_SHR  = 3'd3;
	localparam logic [2:0] S_SHW  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [OP_W-1:0]    op_q;
	logic [GADDR_W-1:0] addr_q;
	logic [COUNT_W-1:0] idx_q, idx_d;
	logic [COUNT_W-1:0] count_q, count_d;
	flags_t             flags_q, flags_d;
	logic               class_d;
	logic [COUNT_W-1:0] idx_inc;

	assign class_d = (in_addr[GADDR_W-1 -: 4] == CLASS_D_PREFIX);
	assign idx_inc = idx_q + COUNT_W'(1);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_flags = flags_q;
	assign res_count = count_q;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		flags_d   = flags_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					idx_d   = '0;
					flags_d = '{status: ST_OK, default: 1'b0};
					if (in_op == OP_NONE || (in_op != OP_FIND && (!class_d || !cfg.enabled))) begin
						flags_d.status = ST_ERR;
						state_d        = S_DONE;
					end else if (in_op == OP_FIND && !cfg.enabled) begin
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (idx_q == count_q) begin
					// scan exhausted: address is absent
					state_d = S_DONE;
					if (op_q == OP_LEAVE) begin
						flags_d.status = ST_ERR;
					end else if (op_q == OP_JOIN) begin
						if (count_q >= cfg.limit) begin
							flags_d.status = ST_FULL;
						end else begin
							ram_we              = 1'b1;
							ram_waddr           = count_q[ADDR_W-1:0];
							ram_wdata.gaddr     = addr_q;
							ram_wdata.refs      = REF_W'(1);
							count_d             = count_q + COUNT_W'(1);
							flags_d.notify_nic  = 1'b1;
							flags_d.send_report = 1'b1;
						end
					end
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (ram_rdata.gaddr == addr_q) begin
					state_d = S_DONE;
					if (op_q == OP_FIND) begin
						flags_d.is_member = 1'b1;
					end else if (op_q == OP_JOIN) begin
						ram_we = 1'b1;
						if (ram_rdata.refs != REF_MAX) begin
							ram_wdata.refs = ram_rdata.refs + REF_W'(1);
						end
					end else begin
						flags_d.notify_nic = 1'b1;
						flags_d.send_leave = 1'b1;
						count_d            = count_q - COUNT_W'(1);
						if (idx_inc < count_q) begin
							state_d = S_SHR;
						end
					end
				end else begin
					idx_d   = idx_inc;
					state_d = S_RD;
				end
			end
			S_SHR: begin
				// fetch the entry above the hole
				ram_raddr = idx_inc[ADDR_W-1:0];
				state_d   = S_SHW;
			end
			S_SHW: begin
				ram_we = 1'b1;
				idx_d  = idx_inc;
				if (idx_inc < count_q) begin
					state_d = S_SHR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		flags_q <= flags_d;
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= in_op;
			addr_q <= in_addr;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_DEPTH))
		else $error("group count exceeds table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + COUNT_W'(1))
		|| (count_q + COUNT_W'(1) == $past(count_q)))
		else $error("group count moved by more than one");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_waddr} <= {1'b0, count_q}))
		else $error("table write beyond the live entries");

	a_count_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (state_q == S_DONE || state_q == S_SHR))
		else $error("group count changed outside a finishing operation");
`endif

endmodule

>>> rtl/core/multicast_group_membership_table.sv
// Multicast group membership table: config registers, output register, entry RAM.
// A rejected item, or a find while disabled, goes straight to its result; a lookup
// reads and compares the live entries in turn (states RD, CMP) until a hit or the end.
// A leave then shifts each later entry down a slot (SHR, SHW). One item at a time: the
// next is taken once the result has passed to the output register and the sequencer
// is back in idle. Reset clears control state, the group count and config (enabled,
// 32 groups); table contents stay undefined, no clear pass.
module multicast_group_membership_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcgt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcgt_pkg::CFG_DATA_W-1:0]   cfg_data,
	mcgt_req_if.sink                          req,
	mcgt_rsp_if.source                        rsp
);
	import mcgt_pkg::*;

	logic               enabled_q;
	logic [MAXG_W-1:0]  max_groups_q;
	cfg_t               cfg;
	logic               res_valid, res_ready;
	flags_t             res_flags;
	logic [COUNT_W-1:0] res_count;
	logic               out_valid_q;
	flags_t             out_flags_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	entry_t             ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b1;
			max_groups_q <= MAXG_W'(TABLE_DEPTH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLED:    enabled_q    <= cfg_data[0];
				CFG_MAX_GROUPS: max_groups_q <= cfg_data[MAXG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.enabled = enabled_q;
	assign cfg.limit   = (max_groups_q > MAXG_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH)
		: COUNT_W'(max_groups_q);

	mcgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.opcode),
		.in_addr   (req.group_addr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_flags (res_flags),
		.res_count (res_count),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	mcgt_ram #(
		.DEPTH  (TABLE_DEPTH),
		.WIDTH  (ENTRY_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: take a finished result whenever the slot is free or draining
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_flags_q <= res_flags;
			out_count_q <= res_count;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_flags_q.status;
	assign rsp.is_member       = out_flags_q.is_member;
	assign rsp.notify_nic      = out_flags_q.notify_nic;
	assign rsp.send_report     = out_flags_q.send_report;
	assign rsp.send_leave      = out_flags_q.send_leave;
	assign rsp.group_count_now = out_count_q;

endmodule

>>> tb/mcgt_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the multicast group membership table: keeps its own copy of the
// group table and config, predicts each reply and checks the replies in order.
// Depends on mcgt_pkg for widths, opcodes, status codes and register indexes.
package mcgt_tb_pkg;
	import mcgt_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_member;
		logic                notify_nic;
		logic                send_report;
		logic                send_leave;
		logic [COUNT_W-1:0]  group_count_now;
	} membership_reply_t;

	class membership_scoreboard;
		logic [GADDR_W-1:0] group_addr_tbl [TABLE_DEPTH];
		logic [REF_W-1:0]   group_refs_tbl [TABLE_DEPTH];
		int unsigned        groups;
		bit                 enabled;
		logic [MAXG_W-1:0]  max_groups;
		membership_reply_t  awaited_replies[$];
		int unsigned        failures;

		function new();
			groups = 0;
			enabled = 1'b1;
			max_groups = MAXG_W'(TABLE_DEPTH);
			failures = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ENABLED: begin
					enabled = data[0];
				end
				CFG_MAX_GROUPS: begin
					max_groups = data[MAXG_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// Apply one operation to the table copy and return the reply it gives.
		function membership_reply_t apply_op(logic [OP_W-1:0] op, logic [GADDR_W-1:0] addr);
			int unsigned       pos;
			int unsigned       lim;
			int unsigned       k;
			bit                hit;
			bit                class_d;
			membership_reply_t r;
			r = '0;
			r.status = ST_OK;
			pos = groups;
			for (k = 0; k < groups; k++) begin
				if (group_addr_tbl[k] == addr) begin
					pos = k;
					break;
				end
			end
			hit = pos < groups;
			class_d = addr[GADDR_W-1 -: 4] == CLASS_D_PREFIX;
			lim = (max_groups > TABLE_DEPTH) ? TABLE_DEPTH : max_groups;
			if (op == OP_FIND) begin
				r.is_member = enabled && hit;
			end else if (op == OP_NONE) begin
				r.status = ST_ERR;
			end else if (!class_d || !enabled) begin
				r.status = ST_ERR;
			end else if (op == OP_JOIN) begin
				if (hit) begin
					if (group_refs_tbl[pos] != REF_MAX)
						group_refs_tbl[pos]++;
				end else if (groups >= lim) begin
					r.status = ST_FULL;
				end else begin
					group_addr_tbl[groups] = addr;
					group_refs_tbl[groups] = REF_W'(1);
					groups++;
					r.notify_nic = 1'b1;
					r.send_report = 1'b1;
				end
			end else begin
				if (!hit) begin
					r.status = ST_ERR;
				end else begin
					// close the gap left by the removed entry
					for (k = pos; k + 1 < groups; k++) begin
						group_addr_tbl[k] = group_addr_tbl[k + 1];
						group_refs_tbl[k] = group_refs_tbl[k + 1];
					end
					groups--;
					r.notify_nic = 1'b1;
					r.send_leave = 1'b1;
				end
			end
			r.group_count_now = COUNT_W'(groups);
			return r;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [GADDR_W-1:0] addr);
			awaited_replies.push_back(apply_op(op, addr));
		endfunction

		function void report_failure(string what, membership_reply_t want, membership_reply_t got);
			failures++;
			if (failures <= 10)
				$display("%s: expected st=%0d mem=%0b nic=%0b rep=%0b lv=%0b cnt=%0d, %s",
					what, want.status, want.is_member, want.notify_nic, want.send_report,
					want.send_leave, want.group_count_now,
					$sformatf("got st=%0d mem=%0b nic=%0b rep=%0b lv=%0b cnt=%0d",
						got.status, got.is_member, got.notify_nic, got.send_report,
						got.send_leave, got.group_count_now));
		endfunction

		function void check_reply(membership_reply_t got);
			membership_reply_t want;
			if (awaited_replies.size() == 0) begin
				report_failure("reply with none awaited", '0, got);
			end else begin
				want = awaited_replies.pop_front();
				if (got.status !== want.status || got.is_member !== want.is_member ||
					got.notify_nic !== want.notify_nic || got.send_report !== want.send_report ||
					got.send_leave !== want.send_leave ||
					got.group_count_now !== want.group_count_now)
					report_failure("reply mismatch", want, got);
			end
		endfunction

		function int unsigned outstanding();
			return awaited_replies.size();
		endfunction
	endclass

endpackage

>>> tb/tb_multicast_group_membership_table.sv
`timescale 1ns / 100ps
// Top-level testbench for multicast_group_membership_table: directed and random
// find/join/leave traffic under varying config, idling and back-pressure.
// Depends on mcgt_pkg, the request/response interfaces and mcgt_tb_pkg.
module tb_multicast_group_membership_table;
	import mcgt_pkg::*;
	import mcgt_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          PHASE_ITEMS = 125;
	localparam int          POOL_SIZE   = 48;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mcgt_req_if req_ch();
	mcgt_rsp_if rsp_ch();

	membership_scoreboard table_model;
	int                   send_idle_pct;
	int                   stall_pct;
	int                   hold_cycles;
	int unsigned          cycle_count = 0;
	logic [GADDR_W-1:0]   group_pool [POOL_SIZE];

	multicast_group_membership_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Reply side: check each transaction, then choose ready for the next cycle.
	initial begin
		membership_reply_t got;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.status, rsp_ch.is_member, rsp_ch.notify_nic,
					rsp_ch.send_report, rsp_ch.send_leave, rsp_ch.group_count_now};
				table_model.check_reply(got);
			end
			if (hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [GADDR_W-1:0] addr);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.group_addr <= addr;
		do @(posedge clk); while (!req_ch.ready);
		table_model.note_request(op, addr);
	endtask

	// Drop valid and hold until every awaited reply is in.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (table_model.outstanding() != 0);
	endtask

	task automatic configure(input bit en, input logic [MAXG_W-1:0] mg);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ENABLED;
		cfg_data <= CFG_DATA_W'(en);
		@(posedge clk);
		table_model.write_register(CFG_ENABLED, CFG_DATA_W'(en));
		cfg_index <= CFG_MAX_GROUPS;
		cfg_data <= mg;
		@(posedge clk);
		table_model.write_register(CFG_MAX_GROUPS, mg);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed joins/leaves/finds on a pool of groups, plus noise.
	task automatic random_item(input int span);
		int                 r;
		logic [OP_W-1:0]    op;
		logic [GADDR_W-1:0] addr;
		r = $urandom_range(99);
		addr = group_pool[$urandom_range(span - 1)];
		if (r < 40) begin
			op = OP_JOIN;
		end else if (r < 65) begin
			op = OP_LEAVE;
		end else if (r < 80) begin
			op = OP_FIND;
		end else if (r < 90) begin
			op = OP_W'($urandom_range(3));
			addr = $urandom;
		end else begin
			op = $urandom_range(1) ? OP_JOIN : OP_LEAVE;
			addr = $urandom;
			if (addr[GADDR_W-1 -: 4] == CLASS_D_PREFIX)
				addr[GADDR_W-4] = ~addr[GADDR_W-4];
		end
		send_item(op, addr);
	endtask

	task automatic run_phase(input bit en, input logic [MAXG_W-1:0] mg, input int idle,
		input int stall, input int span, input int hold, input int pause_at);
		configure(en, mg);
		send_idle_pct = idle;
		stall_pct = stall;
		hold_cycles = hold;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n == pause_at)
				drain();
			random_item(span);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLED;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_FIND;
		req_ch.group_addr = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		table_model = new();
		group_pool[0] = 32'hE000_0000;
		group_pool[1] = 32'hEFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			group_pool[i] = {CLASS_D_PREFIX, 28'($urandom)};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, first join, join hit, lowest and highest class D addresses
		send_item(OP_FIND, 32'hE000_0000);
		send_item(OP_JOIN, 32'hE000_0000);
		send_item(OP_JOIN, 32'hE000_0000);
		send_item(OP_FIND, 32'hE000_0000);
		send_item(OP_JOIN, 32'hEFFF_FFFF);
		// addresses outside class D, find of one, the no-op opcode
		send_item(OP_JOIN, 32'h0000_0000);
		send_item(OP_LEAVE, 32'hFFFF_FFFF);
		send_item(OP_LEAVE, 32'hDFFF_FFFF);
		send_item(OP_FIND, 32'hFFFF_FFFF);
		send_item(OP_NONE, 32'hE000_0000);
		// leave of an absent group, then leave of the head entry
		send_item(OP_LEAVE, 32'hE123_4567);
		send_item(OP_LEAVE, 32'hE000_0000);
		send_item(OP_FIND, 32'hEFFF_FFFF);
		drain();
		// multicast off: finds miss, joins and leaves are refused
		configure(1'b0, MAXG_W'(32));
		send_item(OP_FIND, 32'hEFFF_FFFF);
		send_item(OP_JOIN, 32'hEABC_DEF0);
		send_item(OP_LEAVE, 32'hEFFF_FFFF);
		drain();
		// limit of one with one group held, then a limit of zero
		configure(1'b1, MAXG_W'(1));
		send_item(OP_JOIN, 32'hE000_0001);
		send_item(OP_JOIN, 32'hEFFF_FFFF);
		drain();
		configure(1'b1, MAXG_W'(0));
		send_item(OP_JOIN, 32'hE000_0002);
		send_item(OP_LEAVE, 32'hEFFF_FFFF);
		send_item(OP_JOIN, 32'hE000_0003);
		drain();

		run_phase(1'b1, MAXG_W'(32), 0, 0, POOL_SIZE, 0, -1);
		run_phase(1'b1, MAXG_W'(63), 60, 0, POOL_SIZE, 0, -1);
		run_phase(1'b1, MAXG_W'(1), 0, 60, 6, 0, -1);
		run_phase(1'b1, MAXG_W'(32), 7, 7, POOL_SIZE, 400, -1);
		run_phase(1'b0, MAXG_W'(20), 60, 0, POOL_SIZE, 0, -1);
		run_phase(1'b1, MAXG_W'(5), 0, 0, 10, 0, 60);
		run_phase(1'b1, MAXG_W'(0), 7, 7, POOL_SIZE, 0, -1);
		run_phase(1'b1, MAXG_W'(32), 0, 60, 40, 0, -1);

		repeat (200) @(posedge clk);
		if (table_model.failures == 0 && table_model.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mcgt_pkg.sv
rtl/core/mcgt_req_if.sv
rtl/core/mcgt_rsp_if.sv
rtl/core/mcgt_ram.sv
rtl/core/mcgt_ctrl.sv
rtl/core/multicast_group_membership_table.sv
tb/mcgt_tb_pkg.sv
tb/tb_multicast_group_membership_table.sv
